[rtl/hsvm_pkg.sv]
// Shared types, constants and register map for the HSV hue color mask.
package hsvm_pkg;

	// Datapath widths
	localparam int unsigned CH_W   = 8;   // widened color channel
	localparam int unsigned HUE_W  = 9;   // hue in degrees, 0..359
	localparam int unsigned NUM_W  = 14;  // 60 * |channel difference|
	localparam int unsigned QUO_W  = 6;   // quotient magnitude, 0..60
	localparam int unsigned ADDR_W = 4;   // byte address of the register file
	localparam int unsigned DATA_W = 32;

	// Hue offsets of the three sectors and the full circle
	localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
	localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;

	// Register reset values
	localparam logic [HUE_W-1:0] HUE_LOW_RST    = 9'd340;
	localparam logic [HUE_W-1:0] HUE_HIGH_RST   = 9'd20;
	localparam logic [CH_W-1:0]  MIN_VALUE_RST  = 8'd50;
	localparam logic [CH_W-1:0]  MIN_CHROMA_RST = 8'd20;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_HUE_LOW    = 2'd0,
		REG_HUE_HIGH   = 2'd1,
		REG_MIN_VALUE  = 2'd2,
		REG_MIN_CHROMA = 2'd3
	} reg_idx_t;

	// Channel that holds the maximum
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Side information that travels alongside the divider
	typedef struct packed {
		sector_t         sector;
		logic            neg;     // hue numerator below zero
		logic            gray;    // chroma is zero
		logic [CH_W-1:0] vmax;
		logic [CH_W-1:0] chroma;
	} pix_info_t;

endpackage

[rtl/hsvm_div.sv]
// Three-stage restoring divider for the hue quotient, two bits per stage.
module hsvm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [hsvm_pkg::NUM_W-1:0]     num,
	input  logic [hsvm_pkg::CH_W-1:0]      den,
	input  hsvm_pkg::pix_info_t            in_info,
	output logic                           out_valid,
	output logic [hsvm_pkg::QUO_W-1:0]     quo,
	output hsvm_pkg::pix_info_t            out_info
);

	// Two restoring steps, divisor shifted by sh and then sh-1
	function automatic logic [hsvm_pkg::NUM_W+1:0] div_pair(
		input logic [hsvm_pkg::NUM_W-1:0] rem,
		input logic [hsvm_pkg::CH_W-1:0]  d,
		input int unsigned                sh
	);
		logic [hsvm_pkg::NUM_W-1:0] r;
		logic [hsvm_pkg::NUM_W-1:0] dsh;
		logic [1:0]                 q;
		int unsigned                k;
		r = rem;
		q = 2'b00;
		for (k = 0; k < 2; k++) begin
			dsh = hsvm_pkg::NUM_W'(d) << (sh - k);
			if (r >= dsh) begin
				r        = r - dsh;
				q[1 - k] = 1'b1;
			end
		end
		return {r, q};
	endfunction

	logic [hsvm_pkg::NUM_W+1:0] step1;
	logic [hsvm_pkg::NUM_W+1:0] step2;
	logic [hsvm_pkg::NUM_W+1:0] step3;

	logic                       valid_s1, valid_s2, valid_s3;
	logic [hsvm_pkg::NUM_W-1:0] rem_s1, rem_s2;
	logic [hsvm_pkg::CH_W-1:0]  den_s1, den_s2;
	logic [1:0]                 q_s1;
	logic [3:0]                 q_s2;
	logic [5:0]                 q_s3;
	hsvm_pkg::pix_info_t        info_s1, info_s2, info_s3;

	// Quotient bits 5:4, 3:2 and 1:0
	assign step1 = div_pair(num, den, 5);
	assign step2 = div_pair(rem_s1, den_s1, 3);
	assign step3 = div_pair(rem_s2, den_s2, 1);

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Advance remainder, quotient and side information
	always_ff @(posedge clk) begin
		rem_s1  <= step1[hsvm_pkg::NUM_W+1:2];
		q_s1    <= step1[1:0];
		den_s1  <= den;
		info_s1 <= in_info;

		rem_s2  <= step2[hsvm_pkg::NUM_W+1:2];
		q_s2    <= {q_s1, step2[1:0]};
		den_s2  <= den_s1;
		info_s2 <= info_s1;

		q_s3    <= {q_s2, step3[1:0]};
		info_s3 <= info_s2;
	end

	assign out_valid = valid_s3;
	assign quo       = q_s3;
	assign out_info  = info_s3;

endmodule

[rtl/hsv_hue_color_mask_core.sv]
// Top level of the RGB565 hue threshold mask with its register file.
// A pixel passes through the channel stage, the scaling stage, the three divider stages
// and the output register before its result shows.
// Throughput: one pixel per cycle; busy is always low and the pipeline never stalls.
// The receiver cannot stall: each result shows on done/color_match for one cycle.
// Reset clears the valid bits and loads the register defaults.
module hsv_hue_color_mask_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [15:0]                     pixel,
	output logic                            done,
	output logic                            color_match,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hsvm_pkg::ADDR_W-1:0]     paddr,
	input  logic [hsvm_pkg::DATA_W-1:0]     pwdata,
	output logic [hsvm_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [hsvm_pkg::HUE_W-1:0] hue_low_q, hue_high_q;
	logic [hsvm_pkg::CH_W-1:0]  min_value_q, min_chroma_q;
	hsvm_pkg::reg_idx_t         reg_idx;
	logic                       wr_en;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = hsvm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q    <= hsvm_pkg::HUE_LOW_RST;
			hue_high_q   <= hsvm_pkg::HUE_HIGH_RST;
			min_value_q  <= hsvm_pkg::MIN_VALUE_RST;
			min_chroma_q <= hsvm_pkg::MIN_CHROMA_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				hsvm_pkg::REG_HUE_LOW:    hue_low_q    <= pwdata[hsvm_pkg::HUE_W-1:0];
				hsvm_pkg::REG_HUE_HIGH:   hue_high_q   <= pwdata[hsvm_pkg::HUE_W-1:0];
				hsvm_pkg::REG_MIN_VALUE:  min_value_q  <= pwdata[hsvm_pkg::CH_W-1:0];
				hsvm_pkg::REG_MIN_CHROMA: min_chroma_q <= pwdata[hsvm_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			hsvm_pkg::REG_HUE_LOW:    prdata = hsvm_pkg::DATA_W'(hue_low_q);
			hsvm_pkg::REG_HUE_HIGH:   prdata = hsvm_pkg::DATA_W'(hue_high_q);
			hsvm_pkg::REG_MIN_VALUE:  prdata = hsvm_pkg::DATA_W'(min_value_q);
			hsvm_pkg::REG_MIN_CHROMA: prdata = hsvm_pkg::DATA_W'(min_chroma_q);
			default:                  prdata = '0;
		endcase
	end

	// Stage 1: widen channels, find max/min, pick sector and numerator
	logic [hsvm_pkg::CH_W-1:0] r8, g8, b8, ch_max, ch_min, op_a, op_b;
	hsvm_pkg::sector_t         sector;
	hsvm_pkg::pix_info_t       info_d;

	always_comb begin
		r8 = {pixel[15:11], 3'b000};
		g8 = {pixel[10:5], 2'b00};
		b8 = {pixel[4:0], 3'b000};
		ch_max = r8;
		ch_min = r8;
		if (g8 > ch_max) ch_max = g8;
		if (b8 > ch_max) ch_max = b8;
		if (g8 < ch_min) ch_min = g8;
		if (b8 < ch_min) ch_min = b8;
		// ties go red, then green, then blue
		if (ch_max == r8) begin
			sector = hsvm_pkg::SEC_RED;
			op_a   = g8;
			op_b   = b8;
		end else if (ch_max == g8) begin
			sector = hsvm_pkg::SEC_GREEN;
			op_a   = b8;
			op_b   = r8;
		end else begin
			sector = hsvm_pkg::SEC_BLUE;
			op_a   = r8;
			op_b   = g8;
		end
		info_d.sector = sector;
		info_d.neg    = (op_a < op_b);
		info_d.vmax   = ch_max;
		info_d.chroma = ch_max - ch_min;
		info_d.gray   = (ch_max == ch_min);
	end

	logic                      valid_s1;
	logic [hsvm_pkg::CH_W-1:0] absd_s1;
	hsvm_pkg::pix_info_t       info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		absd_s1 <= info_d.neg ? (op_b - op_a) : (op_a - op_b);
		info_s1 <= info_d;
	end

	// Stage 2: scale the difference by 60
	logic                       valid_s2;
	logic [hsvm_pkg::NUM_W-1:0] num_s2;
	hsvm_pkg::pix_info_t        info_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		num_s2  <= (hsvm_pkg::NUM_W'(absd_s1) << 6) - (hsvm_pkg::NUM_W'(absd_s1) << 2);
		info_s2 <= info_s1;
	end

	// Stages 3-5: divide by chroma
	logic                       div_valid;
	logic [hsvm_pkg::QUO_W-1:0] quo;
	hsvm_pkg::pix_info_t        div_info;

	hsvm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.num       (num_s2),
		.den       (info_s2.chroma),
		.in_info   (info_s2),
		.out_valid (div_valid),
		.quo       (quo),
		.out_info  (div_info)
	);

	// Output stage: assemble hue and test thresholds
	logic [hsvm_pkg::HUE_W-1:0] hue, quo9;
	logic                       in_range, match;

	always_comb begin
		quo9 = hsvm_pkg::HUE_W'(quo);
		case (div_info.sector)
			hsvm_pkg::SEC_RED:
				hue = !div_info.neg ? quo9 : ((quo == '0) ? '0 : hsvm_pkg::HUE_FULL - quo9);
			hsvm_pkg::SEC_GREEN:
				hue = div_info.neg ? hsvm_pkg::HUE_GREEN - quo9 : hsvm_pkg::HUE_GREEN + quo9;
			default:
				hue = div_info.neg ? hsvm_pkg::HUE_BLUE - quo9 : hsvm_pkg::HUE_BLUE + quo9;
		endcase
		if (div_info.gray) hue = '0;
		if (hue_low_q < hue_high_q)
			in_range = (hue >= hue_low_q) && (hue <= hue_high_q);
		else
			in_range = (hue >= hue_low_q) || (hue <= hue_high_q);
		match = div_valid && in_range && (div_info.vmax > min_value_q)
			&& (div_info.chroma > min_chroma_q);
	end

	// Register the result strobe and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			color_match <= 1'b0;
		end else begin
			done        <= div_valid;
			color_match <= match;
		end
	end

endmodule

[rtl/hsvm_checker.sv]
// Port-level assertions for the hue color mask, bound to the top level.
module hsvm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [15:0]                     pixel,
	input logic                            done,
	input logic                            color_match,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [hsvm_pkg::ADDR_W-1:0]     paddr,
	input logic [hsvm_pkg::DATA_W-1:0]     pwdata,
	input logic [hsvm_pkg::DATA_W-1:0]     prdata
);

	logic accept, gray_px, wr_hue_low, rd_hue_low;

	assign accept     = start && !busy;
	assign gray_px    = (pixel[10:5] == {pixel[15:11], 1'b0}) && (pixel[4:0] == pixel[15:11]);
	assign wr_hue_low = psel && penable && pwrite && (paddr[3:2] == hsvm_pkg::REG_HUE_LOW);
	assign rd_hue_low = psel && !pwrite && (paddr[3:2] == hsvm_pkg::REG_HUE_LOW);

	// Every accepted transaction gives a result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("missing result strobe");

	// No result without an earlier accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result strobe without transaction");

	// A gray pixel never matches
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && gray_px) |-> ##6 !color_match)
		else $error("gray pixel flagged as match");

	// The flag is low outside result cycles
	a_flag_qual: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !color_match)
		else $error("match flag without strobe");

	// A written hue bound reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_hue_low ##1 rd_hue_low) |-> (prdata[hsvm_pkg::HUE_W-1:0]
			== $past(pwdata[hsvm_pkg::HUE_W-1:0])))
		else $error("hue_low readback mismatch");

endmodule

bind hsv_hue_color_mask_core hsvm_checker u_hsvm_checker (.*);
